[src/method_lookup_cache_two_level_core_macros.svh]
// Assertion macros for the two-level method lookup cache.
// Included by the top level; depends on nothing else.
`ifndef METHOD_LOOKUP_CACHE_TWO_LEVEL_CORE_MACROS_SVH
`define METHOD_LOOKUP_CACHE_TWO_LEVEL_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MLC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MLC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define MLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[src/mlc_pkg.sv]
// Shared constants, codes and types of the two-level method lookup cache.
// Used by mlc_hash and the top level; depends on nothing.
package mlc_pkg;

    localparam int PRIMARY_ENTRIES   = 1024;
    localparam int SECONDARY_ENTRIES = 256;
    localparam int ENTRY_BYTES       = 12;

    localparam int P_W  = $clog2(PRIMARY_ENTRIES);
    localparam int S_W  = (SECONDARY_ENTRIES > 1) ? $clog2(SECONDARY_ENTRIES) : 1;
    localparam int PP_W = 2 * P_W;

    // The clearing pass covers the deeper of the two stores.
    localparam int CLR_DEPTH = (PRIMARY_ENTRIES > SECONDARY_ENTRIES) ?
                               PRIMARY_ENTRIES : SECONDARY_ENTRIES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    // Truncated reciprocals: floor((2^W - 1) / divisor). The estimated quotient
    // is never high and at most one below the true one.
    localparam logic [31:0] DIV_MUL =
        32'(64'hFFFF_FFFF / 64'(ENTRY_BYTES));
    localparam logic [31:0] MOD_MUL =
        32'(64'hFFFF_FFFF / 64'(PRIMARY_ENTRIES));
    localparam logic [P_W-1:0] SUB_MUL =
        P_W'(((64'd1 << P_W) - 64'd1) / 64'(SECONDARY_ENTRIES));

    localparam logic [2:0] MODE_LOOKUP         = 3'd0;
    localparam logic [2:0] MODE_PROBE          = 3'd1;
    localparam logic [2:0] MODE_FILL           = 3'd2;
    localparam logic [2:0] MODE_FLUSH_KEY      = 3'd3;
    localparam logic [2:0] MODE_FLUSH_ALL      = 3'd4;
    localparam logic [2:0] MODE_CLEAR_COUNTERS = 3'd5;

    localparam logic [1:0] OUT_MISS      = 2'd0;
    localparam logic [1:0] OUT_PRIMARY   = 2'd1;
    localparam logic [1:0] OUT_SECONDARY = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] class_word;
        logic [31:0] selector_word;
        logic [31:0] fill_result;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] class_word;
        logic [31:0] selector_word;
        logic [31:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic           valid;
        item_t          item;
        logic [P_W-1:0] p_index;
        logic [S_W-1:0] s_index;
    } probe_t;

endpackage

[src/method_lookup_cache_two_level_core.sv]
// Channel | Ports                                        | Transfer
// input   | s_valid s_ready s_mode s_class_word ...      | one operation per transaction
// result  | m_valid m_ready m_outcome m_found_result ... | one result per operation
// One operation per cycle is sustained while results are taken and no clearing pass runs.
// Seven index stages and one RAM read stage, in which the operation executes, lead to the
// result register.
// After reset, and after each flush-all, a clearing pass over CLR_DEPTH entries (1024 here)
// runs over both stores; no transaction is taken then, nor between a flush-all and its pass.
// A full result register that is not taken stalls every stage.
// Top level of the two-level method lookup cache.
// Depends on mlc_pkg, mlc_hash, mlc_ram and the assertion macro header.
`include "method_lookup_cache_two_level_core_macros.svh"
module method_lookup_cache_two_level_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [31:0] s_class_word,
    input  logic [31:0] s_selector_word,
    input  logic [31:0] s_fill_result,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_outcome,
    output logic [31:0] m_found_result,
    output logic [31:0] m_primary_hit_count,
    output logic [31:0] m_secondary_hit_count,
    output logic [31:0] m_miss_total
);
    import mlc_pkg::*;

    typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_DRAIN} state_t;

    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

    state_t             state_reg;
    logic [CLR_W-1:0]   clr_idx_reg;

    logic               adv;
    item_t              in_item;
    probe_t             probe;

    logic               e_valid_reg;
    item_t              e_item_reg;
    logic [P_W-1:0]     e_p_reg;
    logic [S_W-1:0]     e_s_reg;

    entry_t             prim_rdata, sec_rdata;
    logic               pb_valid_reg, sb_valid_reg;
    logic [P_W-1:0]     pb_addr_reg;
    logic [S_W-1:0]     sb_addr_reg;
    entry_t             pb_data_reg, sb_data_reg;

    entry_t             pe, se;
    logic               hit1, hit2, is_lookup;
    logic               prim_we, sec_we;
    entry_t             prim_wd, sec_wd;
    logic [1:0]         outcome;
    logic [31:0]        found;
    logic [31:0]        cnt_primary_reg, cnt_secondary_reg, cnt_miss_reg;
    logic [31:0]        cnt_primary_next, cnt_secondary_next, cnt_miss_next;

    logic               prim_wr_en, sec_wr_en;
    logic [P_W-1:0]     prim_wr_addr;
    logic [S_W-1:0]     sec_wr_addr;
    entry_t             prim_wr_data, sec_wr_data;

    logic               m_valid_reg;
    logic [1:0]         m_outcome_reg;
    logic [31:0]        m_found_reg;
    logic [31:0]        m_primary_reg, m_secondary_reg, m_miss_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && (state_reg == ST_RUN);

    assign in_item.mode          = s_mode;
    assign in_item.class_word    = s_class_word;
    assign in_item.selector_word = s_selector_word;
    assign in_item.fill_result   = s_fill_result;

    mlc_hash u_hash (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_valid && s_ready),
        .in_item  (in_item),
        .probe    (probe)
    );

    // The clearing pass owns the write ports; the pipeline is empty meanwhile.
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            prim_wr_en   = 32'(clr_idx_reg) < 32'(PRIMARY_ENTRIES);
            prim_wr_addr = P_W'(clr_idx_reg);
            prim_wr_data = '0;
            sec_wr_en    = 32'(clr_idx_reg) < 32'(SECONDARY_ENTRIES);
            sec_wr_addr  = S_W'(clr_idx_reg);
            sec_wr_data  = '0;
        end else begin
            prim_wr_en   = adv && e_valid_reg && prim_we;
            prim_wr_addr = e_p_reg;
            prim_wr_data = prim_wd;
            sec_wr_en    = adv && e_valid_reg && sec_we;
            sec_wr_addr  = e_s_reg;
            sec_wr_data  = sec_wd;
        end
    end

    mlc_ram #(.DEPTH(PRIMARY_ENTRIES), .WIDTH(ENTRY_W)) u_prim_ram (
        .aclk    (aclk),
        .rd_en   (adv),
        .rd_addr (probe.p_index),
        .rd_data (prim_rdata),
        .wr_en   (prim_wr_en),
        .wr_addr (prim_wr_addr),
        .wr_data (prim_wr_data)
    );

    mlc_ram #(.DEPTH(SECONDARY_ENTRIES), .WIDTH(ENTRY_W)) u_sec_ram (
        .aclk    (aclk),
        .rd_en   (adv),
        .rd_addr (probe.s_index),
        .rd_data (sec_rdata),
        .wr_en   (sec_wr_en),
        .wr_addr (sec_wr_addr),
        .wr_data (sec_wr_data)
    );

    // The RAM read was taken at the same edge as the previous operation's write, so
    // that write is forwarded here when the address matches.
    assign pe = (pb_valid_reg && pb_addr_reg == e_p_reg) ? pb_data_reg : prim_rdata;
    assign se = (sb_valid_reg && sb_addr_reg == e_s_reg) ? sb_data_reg : sec_rdata;

    assign hit1 = pe.valid && pe.class_word == e_item_reg.class_word
                  && pe.selector_word == e_item_reg.selector_word;
    assign hit2 = se.valid && se.class_word == e_item_reg.class_word
                  && se.selector_word == e_item_reg.selector_word;
    assign is_lookup = (e_item_reg.mode == MODE_LOOKUP);

    always_comb begin
        outcome            = OUT_MISS;
        found              = '0;
        prim_we            = 1'b0;
        sec_we             = 1'b0;
        prim_wd            = se;
        sec_wd             = pe;
        cnt_primary_next   = cnt_primary_reg;
        cnt_secondary_next = cnt_secondary_reg;
        cnt_miss_next      = cnt_miss_reg;
        case (e_item_reg.mode)
            MODE_LOOKUP, MODE_PROBE: begin
                if (hit1) begin
                    outcome = OUT_PRIMARY;
                    found   = pe.value;
                    if (is_lookup) begin
                        cnt_primary_next = cnt_primary_reg + 32'd1;
                    end
                end else if (hit2) begin
                    // Swap the two entries.
                    prim_we = 1'b1;
                    sec_we  = 1'b1;
                    outcome = OUT_SECONDARY;
                    found   = se.value;
                    if (is_lookup) begin
                        cnt_secondary_next = cnt_secondary_reg + 32'd1;
                    end
                end else if (is_lookup) begin
                    cnt_miss_next = cnt_miss_reg + 32'd1;
                end
            end
            MODE_FILL: begin
                if (e_item_reg.fill_result != '0) begin
                    sec_we                = 1'b1;
                    prim_we               = 1'b1;
                    prim_wd.valid         = 1'b1;
                    prim_wd.class_word    = e_item_reg.class_word;
                    prim_wd.selector_word = e_item_reg.selector_word;
                    prim_wd.value         = e_item_reg.fill_result;
                end
            end
            MODE_FLUSH_KEY: begin
                sec_wd       = se;
                sec_wd.valid = 1'b0;
                if (hit1) begin
                    prim_we = 1'b1;
                    sec_we  = 1'b1;
                end else if (hit2) begin
                    sec_we  = 1'b1;
                end
            end
            MODE_FLUSH_ALL, MODE_CLEAR_COUNTERS: begin
                cnt_primary_next   = '0;
                cnt_secondary_next = '0;
                cnt_miss_next      = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    if (clr_idx_reg == CLR_LAST) begin
                        state_reg   <= ST_RUN;
                        clr_idx_reg <= '0;
                    end else begin
                        clr_idx_reg <= clr_idx_reg + CLR_W'(1);
                    end
                end
                ST_RUN: begin
                    if (s_valid && s_ready && s_mode == MODE_FLUSH_ALL) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (adv && e_valid_reg && e_item_reg.mode == MODE_FLUSH_ALL) begin
                        state_reg   <= ST_CLEAR;
                        clr_idx_reg <= '0;
                    end
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg       <= 1'b0;
            pb_valid_reg      <= 1'b0;
            sb_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            cnt_primary_reg   <= '0;
            cnt_secondary_reg <= '0;
            cnt_miss_reg      <= '0;
        end else if (adv) begin
            e_valid_reg  <= probe.valid;
            pb_valid_reg <= e_valid_reg && prim_we;
            sb_valid_reg <= e_valid_reg && sec_we;
            m_valid_reg  <= e_valid_reg;
            if (e_valid_reg) begin
                cnt_primary_reg   <= cnt_primary_next;
                cnt_secondary_reg <= cnt_secondary_next;
                cnt_miss_reg      <= cnt_miss_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_item_reg  <= probe.item;
            e_p_reg     <= probe.p_index;
            e_s_reg     <= probe.s_index;
            pb_addr_reg <= e_p_reg;
            pb_data_reg <= prim_wd;
            sb_addr_reg <= e_s_reg;
            sb_data_reg <= sec_wd;
            if (e_valid_reg) begin
                m_outcome_reg   <= outcome;
                m_found_reg     <= found;
                m_primary_reg   <= cnt_primary_next;
                m_secondary_reg <= cnt_secondary_next;
                m_miss_reg      <= cnt_miss_next;
            end
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_outcome             = m_outcome_reg;
    assign m_found_result        = m_found_reg;
    assign m_primary_hit_count   = m_primary_reg;
    assign m_secondary_hit_count = m_secondary_reg;
    assign m_miss_total          = m_miss_reg;

    // Nothing may be in flight while the clearing pass owns the RAMs.
    `MLC_ASSERT_SAME(a_clear_pipe_empty, aclk, aresetn, state_reg == ST_CLEAR,
                     !e_valid_reg && !probe.valid,
                     "operation in flight during clearing pass")
    // Installed results are never zero, so any hit returns a nonzero result.
    `MLC_ASSERT_SAME(a_hit_nonzero, aclk, aresetn,
                     m_valid_reg && m_outcome_reg != OUT_MISS, m_found_reg != '0,
                     "hit returned an empty result")
    // A clearing pass always starts with the counters cleared.
    `MLC_ASSERT_SAME(a_clear_counters, aclk, aresetn,
                     state_reg == ST_CLEAR && clr_idx_reg == '0,
                     cnt_primary_reg == '0 && cnt_secondary_reg == '0 && cnt_miss_reg == '0,
                     "counters not cleared at start of clearing pass")

endmodule

[src/mlc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// A read and a write at the same edge return the old contents. No dependencies.
module mlc_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/mlc_hash.sv]
// Index pipeline of the lookup cache: divides the key hash by the entry size and
// reduces it to primary and secondary indices. Depends on mlc_pkg.
module mlc_hash (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           in_valid,
    input  mlc_pkg::item_t in_item,
    output mlc_pkg::probe_t probe
);
    import mlc_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    item_t it1_reg, it2_reg, it3_reg, it4_reg, it5_reg, it6_reg, it7_reg;

    logic [63:0]      prod1_reg;
    logic [31:0]      q3_reg;
    logic [31:0]      q4_reg;
    logic [63:0]      prod2_reg;
    logic [P_W-1:0]   p5_reg;
    logic [P_W-1:0]   p6_reg;
    logic [PP_W-1:0]  prod3_reg;
    logic [P_W-1:0]   p7_reg;
    logic [S_W-1:0]   s7_reg;

    logic [31:0]      x1, x2;
    logic [31:0]      q0a, rem_a, q3_next;
    logic [31:0]      q0b, rem_b;
    logic [P_W-1:0]   p5_next;
    logic [P_W-1:0]   q0c;
    logic [31:0]      rem_c;
    logic [S_W-1:0]   s7_next;

    always_comb begin
        x1 = it1_reg.class_word ^ it1_reg.selector_word;
        x2 = it2_reg.class_word ^ it2_reg.selector_word;

        // Quotient by the entry size, one correction step.
        q0a     = prod1_reg[63:32];
        rem_a   = x2 - q0a * 32'(ENTRY_BYTES);
        q3_next = (rem_a >= 32'(ENTRY_BYTES)) ? q0a + 32'd1 : q0a;

        // Remainder by the primary size.
        q0b     = prod2_reg[63:32];
        rem_b   = q4_reg - q0b * 32'(PRIMARY_ENTRIES);
        p5_next = P_W'((rem_b >= 32'(PRIMARY_ENTRIES)) ?
                       rem_b - 32'(PRIMARY_ENTRIES) : rem_b);

        // Remainder of the primary index by the secondary size.
        q0c     = prod3_reg[PP_W-1:P_W];
        rem_c   = 32'(p6_reg) - 32'(q0c) * 32'(SECONDARY_ENTRIES);
        s7_next = S_W'((rem_c >= 32'(SECONDARY_ENTRIES)) ?
                       rem_c - 32'(SECONDARY_ENTRIES) : rem_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            it1_reg   <= in_item;
            it2_reg   <= it1_reg;
            it3_reg   <= it2_reg;
            it4_reg   <= it3_reg;
            it5_reg   <= it4_reg;
            it6_reg   <= it5_reg;
            it7_reg   <= it6_reg;
            prod1_reg <= 64'(x1) * 64'(DIV_MUL);
            q3_reg    <= q3_next;
            q4_reg    <= q3_reg;
            prod2_reg <= 64'(q3_reg) * 64'(MOD_MUL);
            p5_reg    <= p5_next;
            p6_reg    <= p5_reg;
            prod3_reg <= PP_W'(p5_reg) * PP_W'(SUB_MUL);
            p7_reg    <= p6_reg;
            s7_reg    <= s7_next;
        end
    end

    assign probe.valid   = v7_reg;
    assign probe.item    = it7_reg;
    assign probe.p_index = p7_reg;
    assign probe.s_index = s7_reg;

endmodule
